// ===== rtl/upq_pkg.sv =====
// shared types and constants for the unsorted array priority queue
`default_nettype none

package upq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int PRIO_W        = 16;
   localparam int ENTRY_W       = DATA_W + PRIO_W;
   localparam int OCC_W         = 5;
   localparam int CAP_W         = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_REMOVED   = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_START,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   out_data;
      logic [PRIO_W-1:0]          out_priority;
      logic [OCC_W-1:0]           occupancy;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/unsorted_array_priority_queue_top.sv =====
// top level of the unsorted array priority queue
`default_nettype none

// bounded priority queue kept as an unsorted array in arrival order, held in one
// ram word per entry ({priority, data}). a word is taken at a clock edge where
// start is high and busy is low; req_type selects insert or remove. every request
// gives exactly one result word, shown for one cycle with rsp_valid high; the
// receiver cannot stall, so it must take the word in that cycle.
// insert, overflow and underflow: result in the cycle after the request, busy
// stays low, so such requests can follow every cycle.
// remove: a min scan reads the stored entries one per cycle through the single
// ram read port, then, after a setup state when any entry must move, the entries
// after the winner move down one place per cycle, then a done state finishes;
// busy stays high up to and through the done state, and the result word follows
// in the next cycle.
// smallest priority wins, ties go to the oldest entry.
// capacity limits inserts and saturates at DEPTH; write it only while idle.

module unsorted_array_priority_queue_top #(
   parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request side
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_type,
   input  wire logic signed [upq_pkg::DATA_W-1:0] req_in_data,
   input  wire logic        [upq_pkg::PRIO_W-1:0] req_in_priority,
   // response side
   output logic                                   rsp_valid,
   output logic             [1:0]                 rsp_status,
   output logic signed      [upq_pkg::DATA_W-1:0] rsp_out_data,
   output logic             [upq_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic             [upq_pkg::OCC_W-1:0]  rsp_occupancy,
   // capacity register
   input  wire logic                              csr_we,
   input  wire logic        [upq_pkg::CAP_W-1:0]  csr_wdata
);

   import upq_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic [CAP_W-1:0]   capacity_ff, capacity_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   rsp_word_type       rsp_word;

   // capacity register, plain write with no read-back
   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // sequencer: owns the entry count and every ram access
   upq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_in_data     (req_in_data),
      .req_in_priority (req_in_priority),
      .capacity        (capacity_ff),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_word        (rsp_word)
   );

   // entry store, one {priority, data} word per slot, contents undefined until written
   upq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response word out to separate ports
   assign rsp_status       = rsp_word.status;
   assign rsp_out_data     = rsp_word.out_data;
   assign rsp_out_priority = rsp_word.out_priority;
   assign rsp_occupancy    = rsp_word.occupancy;

endmodule

`default_nettype wire

// ===== rtl/upq_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module upq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/upq_ctrl.sv =====
// request sequencer: append, min scan over the ram and shift-down compaction
`default_nettype none

module upq_ctrl #(
   parameter int DEPTH = upq_pkg::DEPTH_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_type,
   input  wire logic signed [upq_pkg::DATA_W-1:0]  req_in_data,
   input  wire logic        [upq_pkg::PRIO_W-1:0]  req_in_priority,
   input  wire logic        [upq_pkg::CAP_W-1:0]   capacity,
   output logic                                    ram_wr_en,
   output logic             [ADDR_W-1:0]           ram_wr_addr,
   output logic             [upq_pkg::ENTRY_W-1:0] ram_wr_data,
   output logic             [ADDR_W-1:0]           ram_rd_addr,
   input  wire logic        [upq_pkg::ENTRY_W-1:0] ram_rd_data,
   output logic                                    rsp_valid,
   output upq_pkg::rsp_word_type                   rsp_word
);

   import upq_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]         best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]        best_prio_ff, best_prio_in;
   logic signed [DATA_W-1:0] best_data_ff, best_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [PRIO_W-1:0]        rd_prio;
   logic signed [DATA_W-1:0] rd_dat;
   logic                     full;
   logic                     take;
   logic [CNT_W-1:0]         cur_best;
   logic [CNT_W-1:0]         last_idx;
   logic [CNT_W-1:0]         count_inc;
   logic [CNT_W-1:0]         shift_rd_idx;

   function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
      logic [CNT_W+OCC_W-1:0] ext;
      ext = {{OCC_W{1'b0}}, c};
      return ext[OCC_W-1:0];
   endfunction

   assign rd_prio      = ram_rd_data[ENTRY_W-1:DATA_W];
   assign rd_dat       = ram_rd_data[DATA_W-1:0];
   assign last_idx     = count_ff - CNT_W'(1);
   assign count_inc    = count_ff + CNT_W'(1);
   assign shift_rd_idx = best_idx_ff + CNT_W'(1);

   // full when the count reaches the programmed capacity or the built depth
   assign full = ({{CAP_W{1'b0}}, count_ff} >= {{CNT_W{1'b0}}, capacity})
              || (count_ff == CNT_W'(DEPTH));

   assign take     = (cmp_idx_ff == '0) || (rd_prio < best_prio_ff);
   assign cur_best = take ? cmp_idx_ff : best_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_data_ff <= best_data_in;
      rsp_word_ff  <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_data_in = best_data_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_idx_ff[ADDR_W-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = rd_idx_ff[ADDR_W-1:0];
      busy         = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            ram_rd_addr = '0;
            if (start) begin
               rsp_word_in.out_data     = '0;
               rsp_word_in.out_priority = '0;
               rsp_word_in.occupancy    = occ_of(count_ff);
               if (req_type == REQ_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_word_in.status = ST_OVERFLOW;
                  end else begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = count_ff[ADDR_W-1:0];
                     ram_wr_data           = {req_in_priority, req_in_data};
                     count_in              = count_inc;
                     rsp_word_in.status    = ST_INSERTED;
                     rsp_word_in.occupancy = occ_of(count_inc);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_word_in.status = ST_UNDERFLOW;
               end else begin
                  // entry 0 is read now, arrives in the first scan cycle
                  rd_idx_in  = CNT_W'(1);
                  cmp_idx_in = '0;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
            cmp_idx_in = cmp_idx_ff + CNT_W'(1);
            if (take) begin
               best_idx_in  = cmp_idx_ff;
               best_prio_in = rd_prio;
               best_data_in = rd_dat;
            end
            if (cmp_idx_ff == last_idx) begin
               state_in = (cur_best == last_idx) ? S_DONE : S_SHIFT_START;
            end
         end
         S_SHIFT_START: begin
            ram_rd_addr = shift_rd_idx[ADDR_W-1:0];
            rd_idx_in   = best_idx_ff + CNT_W'(2);
            cmp_idx_in  = best_idx_ff;
            state_in    = S_SHIFT;
         end
         S_SHIFT: begin
            // entry cmp+1 is on the read data, move it down one place
            ram_wr_en  = 1'b1;
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
            cmp_idx_in = cmp_idx_ff + CNT_W'(1);
            if (CNT_W'(cmp_idx_ff + CNT_W'(2)) == count_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            count_in                 = last_idx;
            rsp_valid_in             = 1'b1;
            rsp_word_in.status       = ST_REMOVED;
            rsp_word_in.out_data     = best_data_ff;
            rsp_word_in.out_priority = best_prio_ff;
            rsp_word_in.occupancy    = occ_of(last_idx);
            state_in                 = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the unsorted array priority queue
`timescale 1ns / 100ps

module tb_top;
   import upq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // margin beyond the busy time of the longest remove
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
   // cycles with no word moving on either side before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 125;

   // one request word as the sender sees it
   typedef struct {
      logic                     op;
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
      bit                       drain_first;  // hold until all results are back
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_type = REQ_INSERT;
   logic signed [DATA_W-1:0] req_in_data = '0;
   logic [PRIO_W-1:0]        req_in_priority = '0;

   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_out_data;
   logic [PRIO_W-1:0]        rsp_out_priority;
   logic [OCC_W-1:0]         rsp_occupancy;

   logic                     csr_we = 1'b0;
   logic [CAP_W-1:0]         csr_wdata = CAP_RESET;

   // pending request words and predicted result words
   req_word_type req_words[$];
   rsp_word_type expected_words[$];
   req_word_type cur_req;

   // shadow of the queue contents and the capacity register
   logic signed [DATA_W-1:0] shadow_data [DEPTH];
   logic [PRIO_W-1:0]        shadow_prio [DEPTH];
   int                       shadow_count = 0;
   int                       shadow_capacity = int'(CAP_RESET);

   int gap_left = 0;
   int burst_left = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int cap_settings = 1;

   unsorted_array_priority_queue_top #(.DEPTH(DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_in_data      (req_in_data),
      .req_in_priority  (req_in_priority),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one request to the shadow queue and return the result word it gives
   function automatic rsp_word_type pq_service(req_word_type w);
      rsp_word_type r;
      int           lim;
      int           best;
      r = '0;
      lim = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
      if (w.op == REQ_INSERT) begin
         // full also covers capacity lowered below the current fill
         if (shadow_count >= lim) begin
            r.status = ST_OVERFLOW;
         end else begin
            shadow_data[shadow_count] = w.data;
            shadow_prio[shadow_count] = w.prio;
            shadow_count++;
            r.status = ST_INSERTED;
         end
      end else if (shadow_count == 0) begin
         r.status = ST_UNDERFLOW;
      end else begin
         // smallest priority wins, strict compare keeps the oldest on a tie
         best = 0;
         for (int i = 1; i < shadow_count; i++) begin
            if (shadow_prio[i] < shadow_prio[best]) best = i;
         end
         r.out_data = shadow_data[best];
         r.out_priority = shadow_prio[best];
         for (int i = best; i + 1 < shadow_count; i++) begin
            shadow_data[i] = shadow_data[i + 1];
            shadow_prio[i] = shadow_prio[i + 1];
         end
         shadow_count--;
         r.status = ST_REMOVED;
      end
      r.occupancy = OCC_W'(shadow_count);
      return r;
   endfunction

   function automatic req_word_type make_req(logic op, logic signed [DATA_W-1:0] data,
                                             logic [PRIO_W-1:0] prio, bit drain_first);
      req_word_type w;
      w.op = op;
      w.data = data;
      w.prio = prio;
      w.drain_first = drain_first;
      return w;
   endfunction

   // random request; priorities lean toward ties and the range ends now and then
   function automatic req_word_type random_req(int insert_pct);
      logic [PRIO_W-1:0] p;
      logic              op;
      case ($urandom_range(0, 2))
         0: p = PRIO_W'($urandom_range(0, 65535));
         1: p = PRIO_W'($urandom_range(0, 3));
         default: begin
            case ($urandom_range(0, 3))
               0: p = '0;
               1: p = PRIO_W'(1);
               2: p = '1 - PRIO_W'(1);
               default: p = '1;
            endcase
         end
      endcase
      op = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      return make_req(op, DATA_W'($urandom), p, $urandom_range(0, 59) == 0);
   endfunction

   // sender gap per word: drawn uniformly, with occasional back-to-back stretches
   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // request driver: a word is taken at an edge where start is high and busy is low
   always @(posedge clock) begin : driver
      bit fired;
      int gap;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         fired = start && !busy;
         gap = gap_left;
         if (fired) begin
            expected_words.push_back(pq_service(cur_req));
            gap = draw_gap();
         end
         if (fired || !start) begin
            if (gap == 0 && req_words.size() != 0 &&
                (!req_words[0].drain_first || expected_words.size() == 0)) begin
               cur_req = req_words.pop_front();
               start <= 1'b1;
               req_type <= cur_req.op;
               req_in_data <= cur_req.data;
               req_in_priority <= cur_req.prio;
               gap_left <= 0;
            end else begin
               start <= 1'b0;
               gap_left <= (gap > 0) ? gap - 1 : 0;
            end
         end
      end
   end

   // result monitor: every strobed word is checked against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result word with nothing expected, status %0d", $time, rsp_status);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               mismatches++;
            end
            if (rsp_out_data !== want.out_data) begin
               $display("%0t: out_data expected %0d got %0d",
                        $time, want.out_data, rsp_out_data);
               mismatches++;
            end
            if (rsp_out_priority !== want.out_priority) begin
               $display("%0t: out_priority expected %0d got %0d",
                        $time, want.out_priority, rsp_out_priority);
               mismatches++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d got %0d",
                        $time, want.occupancy, rsp_occupancy);
               mismatches++;
            end
         end
      end
   end

   // hang detection: counts cycles in which no word moves on either side
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // wait until every word is sent and answered, then let a long remove finish
   task automatic wait_quiet();
      while (req_words.size() != 0 || start || expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // capacity is only changed with the queue block idle
   task automatic write_capacity(int value);
      wait_quiet();
      csr_we <= 1'b1;
      csr_wdata <= CAP_W'(value);
      shadow_capacity = value;
      @(posedge clock);
      csr_we <= 1'b0;
      cap_settings++;
   endtask

   initial begin : stimulus
      int caps [8];
      int insert_pct;
      // zero refuses all inserts, 31 saturates at depth; leftovers from one
      // phase meet a smaller capacity in the next
      caps = '{1, 0, 31, 7, 16, 2, 12, 16};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: underflow on empty, with junk on the ignored fields
      req_words.push_back(make_req(REQ_REMOVE, '1, '1, 1'b0));
      // range ends for data and priority, plus ties on priority 5 and 0
      req_words.push_back(make_req(REQ_INSERT, 32'sh8000_0000, 16'h0005, 1'b0));
      req_words.push_back(make_req(REQ_INSERT, 32'sh7fff_ffff, 16'hffff, 1'b0));
      req_words.push_back(make_req(REQ_INSERT, 32'shffff_ffff, 16'h0005, 1'b0));
      req_words.push_back(make_req(REQ_INSERT, 32'sh0000_0000, 16'h0000, 1'b0));
      req_words.push_back(make_req(REQ_INSERT, 32'sh1234_5678, 16'h0000, 1'b0));
      // fill up to depth
      for (int i = 5; i < DEPTH; i++)
         req_words.push_back(make_req(REQ_INSERT, {i[3:0], 28'ha5a_5a5a},
                                      (i % 2) ? 16'hffff : 16'h7fff, 1'b0));
      // insert into a full queue, sent only once all earlier results are back
      req_words.push_back(make_req(REQ_INSERT, 32'sh5555_aaaa, 16'h0001, 1'b1));
      // removes walk the ties oldest first
      for (int i = 0; i < 7; i++)
         req_words.push_back(make_req(REQ_REMOVE, DATA_W'($urandom),
                                      PRIO_W'($urandom), 1'b0));

      // random phases, each under its own capacity, alternating fill and drain bias
      foreach (caps[ph]) begin
         write_capacity(caps[ph]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            insert_pct = ((k / 30) % 2 == 0) ? 75 : 25;
            req_words.push_back(random_req(insert_pct));
         end
      end

      wait_quiet();
      if (expected_words.size() != 0) mismatches++;
      $display("covered %0d requests over %0d capacity settings",
               status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
               cap_settings);
      $display("inserted %0d, overflow %0d, removed %0d, underflow %0d",
               status_seen[ST_INSERTED], status_seen[ST_OVERFLOW],
               status_seen[ST_REMOVED], status_seen[ST_UNDERFLOW]);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
